>>> rtl/sw_pkg.sv
// shared types and constants for the stopwatch with button qualifiers
`default_nettype none
package sw_pkg;

  localparam int unsigned TICKS_PER_SECOND = 113;

  localparam int unsigned TICK_W  = 7;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned HOUR_W  = 7;
  localparam int unsigned CENTI_W = 7;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned HELD_W  = 8;
  localparam int unsigned LIMIT_W = 8;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [HELD_W-1:0] HOLD_SAT     = 8'd225;
  localparam logic [SEC_W-1:0]  SEC_LAST     = 6'd59;
  localparam logic [MIN_W-1:0]  MIN_LAST     = 6'd59;
  localparam logic [TICK_W-1:0] TICK_LAST    = TICK_W'(TICKS_PER_SECOND - 1);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd70;
  localparam logic [HOUR_W-1:0] HMAX_RESET   = 7'd91;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOURS_MAX   = 1'b1;

  localparam logic [MODE_W-1:0] RUN_CODE_STOPPED = 2'd0;
  localparam logic [MODE_W-1:0] RUN_CODE_RUNNING = 2'd1;
  localparam logic [MODE_W-1:0] RUN_CODE_HOLD    = 2'd2;

  // centiseconds by reciprocal multiply, exact for tick*100 below 2**14
  localparam int unsigned CENTI_SHIFT = 21;
  localparam longint unsigned CENTI_RECIP =
    ((64'd1 << CENTI_SHIFT) + TICKS_PER_SECOND - 1) / TICKS_PER_SECOND;
  localparam int unsigned CENTI_MUL_W = 28;
  localparam logic [CENTI_MUL_W-1:0] CENTI_MUL = CENTI_MUL_W'(100 * CENTI_RECIP);
  localparam int unsigned CENTI_PROD_W = CENTI_MUL_W + TICK_W;

  typedef enum logic [2:0] {
    MODE_STOPPED = 3'b001,
    MODE_RUNNING = 3'b010,
    MODE_HOLD    = 3'b100
  } mode_t;

endpackage
`default_nettype wire

>>> rtl/sw_stream_if.sv
// request channels of the stopwatch: button levels in, time readout out
`default_nettype none
interface sw_in_if
  import sw_pkg::*;
  ;
  logic valid;
  logic ready;
  logic start_button;
  logic hold_button;

  modport source (output valid, output start_button, output hold_button, input ready);
  modport sink (input valid, input start_button, input hold_button, output ready);
endinterface

interface sw_out_if
  import sw_pkg::*;
  ;
  logic                 valid;
  logic                 ready;
  logic [CENTI_W-1:0]   centiseconds;
  logic [SEC_W-1:0]     seconds;
  logic [MIN_W-1:0]     minutes;
  logic [HOUR_W-1:0]    hours;
  logic [MODE_W-1:0]    run_mode;

  modport source (output valid, output centiseconds, output seconds, output minutes,
                  output hours, output run_mode, input ready);
  modport sink (input valid, input centiseconds, input seconds, input minutes,
                input hours, input run_mode, output ready);
endinterface
`default_nettype wire

>>> rtl/stopwatch_with_button_qualifiers.sv
// Stopwatch driven by timer tick requests that carry two button levels. Each
// accepted request qualifies short presses on the start and hold buttons,
// updates the run mode and the time, and yields one readout request. A request
// passes the input register, then the update into the output register; a
// request can be accepted every cycle while the readout side keeps up, and the
// input register can take one more request while a readout still waits.
`default_nettype none
module stopwatch_with_button_qualifiers
  import sw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  sw_in_if.sink                     in_chan,
  sw_out_if.source                  out_chan
);

  logic [LIMIT_W-1:0] press_limit_r;
  logic [HOUR_W-1:0]  hours_max_r;

  logic s1_valid_r, s1_start_r, s1_hold_r;
  logic out_valid_r;
  logic advance;

  mode_t              mode_r, mode_nxt, mode_mid;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [SEC_W-1:0]   sec_r, sec_nxt;
  logic [MIN_W-1:0]   min_r, min_nxt;
  logic [HOUR_W-1:0]  hour_r, hour_nxt;
  logic [HELD_W-1:0]  start_held_r, start_held_nxt;
  logic [HELD_W-1:0]  clear_held_r, clear_held_nxt;
  logic               start_fire, clear_fire;

  logic [CENTI_PROD_W-1:0] centi_prod;
  logic [CENTI_W-1:0]      centi_r;
  logic [SEC_W-1:0]        sec_out_r;
  logic [MIN_W-1:0]        min_out_r;
  logic [HOUR_W-1:0]       hour_out_r;
  logic [MODE_W-1:0]       run_code, run_code_r;

  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_limit_r <= LIMIT_RESET;
      hours_max_r   <= HMAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRESS_LIMIT: press_limit_r <= cfg_wdata;
        CFG_HOURS_MAX:   hours_max_r   <= cfg_wdata[HOUR_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_start_r <= in_chan.start_button;
      s1_hold_r  <= in_chan.hold_button;
    end
  end

  // press qualifiers
  always_comb begin
    start_fire     = 1'b0;
    start_held_nxt = start_held_r;
    if (s1_start_r) begin
      if (start_held_r < HOLD_SAT) begin
        start_held_nxt = start_held_r + 1'b1;
      end
    end else begin
      start_fire     = (start_held_r != '0) && (start_held_r < press_limit_r);
      start_held_nxt = '0;
    end
  end

  always_comb begin
    clear_fire     = 1'b0;
    clear_held_nxt = clear_held_r;
    if (s1_hold_r) begin
      if (clear_held_r < HOLD_SAT) begin
        clear_held_nxt = clear_held_r + 1'b1;
      end
    end else begin
      clear_fire     = (clear_held_r != '0) && (clear_held_r < press_limit_r);
      clear_held_nxt = '0;
    end
  end

  // mode and time update
  always_comb begin
    mode_mid = mode_r;
    if (start_fire) begin
      case (mode_r)
        MODE_STOPPED: mode_mid = MODE_RUNNING;
        MODE_RUNNING: mode_mid = MODE_STOPPED;
        default:      mode_mid = mode_r;
      endcase
    end

    mode_nxt = mode_mid;
    tick_nxt = tick_r;
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;

    if (clear_fire) begin
      case (mode_mid)
        MODE_RUNNING: mode_nxt = MODE_HOLD;
        MODE_HOLD:    mode_nxt = MODE_RUNNING;
        default: begin
          tick_nxt = '0;
          sec_nxt  = '0;
          min_nxt  = '0;
          hour_nxt = '0;
        end
      endcase
    end

    if (mode_nxt == MODE_RUNNING) begin
      if (tick_nxt < TICK_LAST) begin
        tick_nxt = tick_nxt + 1'b1;
      end else begin
        tick_nxt = '0;
        if (sec_nxt < SEC_LAST) begin
          sec_nxt = sec_nxt + 1'b1;
        end else begin
          sec_nxt = '0;
          if (min_nxt < MIN_LAST) begin
            min_nxt = min_nxt + 1'b1;
          end else begin
            min_nxt = '0;
            if (hour_nxt < hours_max_r) begin
              hour_nxt = hour_nxt + 1'b1;
            end else begin
              hour_nxt = '0;
            end
          end
        end
      end
    end
  end

  always_comb begin
    case (mode_nxt)
      MODE_STOPPED: run_code = RUN_CODE_STOPPED;
      MODE_RUNNING: run_code = RUN_CODE_RUNNING;
      MODE_HOLD:    run_code = RUN_CODE_HOLD;
      default:      run_code = RUN_CODE_STOPPED;
    endcase
  end

  assign centi_prod = CENTI_PROD_W'(tick_nxt) * CENTI_PROD_W'(CENTI_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_STOPPED;
      tick_r       <= '0;
      sec_r        <= '0;
      min_r        <= '0;
      hour_r       <= '0;
      start_held_r <= '0;
      clear_held_r <= '0;
    end else if (advance) begin
      mode_r       <= mode_nxt;
      tick_r       <= tick_nxt;
      sec_r        <= sec_nxt;
      min_r        <= min_nxt;
      hour_r       <= hour_nxt;
      start_held_r <= start_held_nxt;
      clear_held_r <= clear_held_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      centi_r    <= centi_prod[CENTI_SHIFT +: CENTI_W];
      sec_out_r  <= sec_nxt;
      min_out_r  <= min_nxt;
      hour_out_r <= hour_nxt;
      run_code_r <= run_code;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.centiseconds = centi_r;
  assign out_chan.seconds      = sec_out_r;
  assign out_chan.minutes      = min_out_r;
  assign out_chan.hours        = hour_out_r;
  assign out_chan.run_mode     = run_code_r;

endmodule
`default_nettype wire

>>> verif/stopwatch_with_button_qualifiers_test.sv
// self-checking testbench for the stopwatch: directed table and random press phases
`timescale 1ns / 1ps
module stopwatch_with_button_qualifiers_test
  import sw_pkg::*;
;

  typedef struct packed {
    logic [CENTI_W-1:0] centiseconds;
    logic [SEC_W-1:0]   seconds;
    logic [MIN_W-1:0]   minutes;
    logic [HOUR_W-1:0]  hours;
    logic [MODE_W-1:0]  run_mode;
  } readout_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     value;
    logic                 start_level;
    logic                 hold_level;
    int unsigned          count;
    logic                 typed;
    readout_t             want;
  } row_t;

  localparam int unsigned PHASE_TICKS = 25;
  localparam int unsigned PHASES = 6;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  sw_in_if in_chan ();
  sw_out_if out_chan ();

  stopwatch_with_button_qualifiers uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // stopwatch state as the block should hold it
  logic [MODE_W-1:0]  watch_mode;
  logic [TICK_W-1:0]  tick_q;
  logic [SEC_W-1:0]   sec_q;
  logic [MIN_W-1:0]   min_q;
  logic [HOUR_W-1:0]  hour_q;
  logic [HELD_W-1:0]  held_ticks [2];
  logic [LIMIT_W-1:0] limit_reg;
  logic [HOUR_W-1:0]  hours_top;

  readout_t readouts_due[$];
  row_t plan[$];
  bit steady;
  int unsigned error_count;
  int unsigned ticks_sent;
  int unsigned readouts_seen;
  int unsigned cfg_writes;
  int unsigned directed_ticks;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timed out with %0d readouts outstanding", readouts_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic short_press(int b, logic level);
    logic fired;
    fired = 1'b0;
    if (level) begin
      if (held_ticks[b] < HOLD_SAT) held_ticks[b] = held_ticks[b] + 1'b1;
    end else begin
      fired = (held_ticks[b] != '0) && (held_ticks[b] < limit_reg);
      held_ticks[b] = '0;
    end
    return fired;
  endfunction

  function automatic readout_t step_watch(logic start_level, logic hold_level);
    readout_t r;
    if (short_press(0, start_level) && watch_mode != RUN_CODE_HOLD) begin
      watch_mode = watch_mode ^ RUN_CODE_RUNNING;
    end
    if (short_press(1, hold_level)) begin
      if (watch_mode == RUN_CODE_RUNNING) begin
        watch_mode = RUN_CODE_HOLD;
      end else if (watch_mode == RUN_CODE_HOLD) begin
        watch_mode = RUN_CODE_RUNNING;
      end else begin
        tick_q = '0;
        sec_q = '0;
        min_q = '0;
        hour_q = '0;
      end
    end
    if (watch_mode == RUN_CODE_RUNNING) begin
      if (tick_q < TICK_LAST) begin
        tick_q = tick_q + 1'b1;
      end else begin
        tick_q = '0;
        if (sec_q < SEC_LAST) begin
          sec_q = sec_q + 1'b1;
        end else begin
          sec_q = '0;
          if (min_q < MIN_LAST) begin
            min_q = min_q + 1'b1;
          end else begin
            min_q = '0;
            hour_q = (hour_q < hours_top) ? hour_q + 1'b1 : '0;
          end
        end
      end
    end
    r.centiseconds = CENTI_W'((int'(tick_q) * 100) / TICKS_PER_SECOND);
    r.seconds = sec_q;
    r.minutes = min_q;
    r.hours = hour_q;
    r.run_mode = watch_mode;
    return r;
  endfunction

  function automatic row_t tick_row(logic s, logic h, int unsigned n);
    row_t r;
    r = '0;
    r.kind = ROW_TICK;
    r.start_level = s;
    r.hold_level = h;
    r.count = n;
    return r;
  endfunction

  function automatic row_t typed_row(logic s, logic h, int unsigned n, int c, int sec,
                                     int mins, int hr, logic [MODE_W-1:0] m);
    row_t r;
    r = tick_row(s, h, n);
    r.typed = 1'b1;
    r.want.centiseconds = CENTI_W'(c);
    r.want.seconds = SEC_W'(sec);
    r.want.minutes = MIN_W'(mins);
    r.want.hours = HOUR_W'(hr);
    r.want.run_mode = m;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.index = idx;
    r.value = val;
    return r;
  endfunction

  task automatic send_tick(logic s, logic h, logic use_typed = 1'b0,
                           readout_t typed_val = '0);
    int unsigned gap;
    readout_t predicted;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.start_button <= s;
    in_chan.hold_button <= h;
    do @(posedge clk); while (!in_chan.ready);
    predicted = step_watch(s, h);
    readouts_due.push_back(use_typed ? typed_val : predicted);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    while (readouts_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PRESS_LIMIT) limit_reg = val;
    else hours_top = val[HOUR_W-1:0];
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      error_count++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // readout side: random stalls, check each accepted request
  initial begin
    int unsigned stall;
    readout_t got;
    readout_t want;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = steady ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      got.centiseconds = out_chan.centiseconds;
      got.seconds = out_chan.seconds;
      got.minutes = out_chan.minutes;
      got.hours = out_chan.hours;
      got.run_mode = out_chan.run_mode;
      readouts_seen++;
      if (readouts_due.size() == 0) begin
        error_count++;
        $display("%0t unexpected readout: expected none, actual %h", $time, got);
      end else begin
        want = readouts_due.pop_front();
        compare_field("centiseconds", want.centiseconds, got.centiseconds);
        compare_field("seconds", want.seconds, got.seconds);
        compare_field("minutes", want.minutes, got.minutes);
        compare_field("hours", want.hours, got.hours);
        compare_field("run_mode", want.run_mode, got.run_mode);
      end
    end
  end

  initial begin
    logic [LIMIT_W-1:0] limit_pick [PHASES];
    logic [HOUR_W-1:0] hours_pick [PHASES];
    row_t r;
    int unsigned phase_start;
    int unsigned choice;
    int unsigned kind;
    int unsigned len;
    int unsigned span;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.start_button = 1'b0;
    in_chan.hold_button = 1'b0;
    out_chan.ready = 1'b0;
    steady = 1'b0;
    error_count = 0;
    ticks_sent = 0;
    readouts_seen = 0;
    cfg_writes = 0;
    watch_mode = RUN_CODE_STOPPED;
    tick_q = '0;
    sec_q = '0;
    min_q = '0;
    hour_q = '0;
    held_ticks[0] = '0;
    held_ticks[1] = '0;
    limit_reg = LIMIT_RESET;
    hours_top = HMAX_RESET;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    plan.push_back(typed_row(0, 0, 1, 0, 0, 0, 0, RUN_CODE_STOPPED));
    plan.push_back(typed_row(1, 0, 1, 0, 0, 0, 0, RUN_CODE_STOPPED));
    plan.push_back(typed_row(0, 0, 1, 0, 0, 0, 0, RUN_CODE_RUNNING));
    plan.push_back(typed_row(0, 0, 112, 0, 1, 0, 0, RUN_CODE_RUNNING));
    plan.push_back(tick_row(0, 1, 1));
    plan.push_back(typed_row(0, 0, 1, 0, 1, 0, 0, RUN_CODE_HOLD));
    // start press is ignored in hold
    plan.push_back(tick_row(1, 0, 1));
    plan.push_back(tick_row(0, 0, 1));
    plan.push_back(tick_row(0, 1, 1));
    plan.push_back(tick_row(0, 0, 1));
    // held exactly the limit, then one below it
    plan.push_back(tick_row(1, 0, 70));
    plan.push_back(tick_row(0, 0, 1));
    plan.push_back(tick_row(1, 0, 69));
    plan.push_back(tick_row(0, 0, 1));
    plan.push_back(tick_row(0, 1, 75));
    plan.push_back(tick_row(0, 0, 1));
    // hold press while stopped clears the time
    plan.push_back(tick_row(0, 1, 1));
    plan.push_back(typed_row(0, 0, 1, 0, 0, 0, 0, RUN_CODE_STOPPED));
    // both buttons at once: start first, then hold
    plan.push_back(tick_row(1, 1, 1));
    plan.push_back(typed_row(0, 0, 1, 0, 0, 0, 0, RUN_CODE_HOLD));
    // limit above saturation: a saturated hold still counts
    plan.push_back(cfg_row(CFG_PRESS_LIMIT, 8'd255));
    plan.push_back(tick_row(0, 1, 226));
    plan.push_back(tick_row(0, 0, 1));
    plan.push_back(cfg_row(CFG_PRESS_LIMIT, 8'd0));
    plan.push_back(tick_row(1, 0, 1));
    plan.push_back(tick_row(0, 0, 1));
    plan.push_back(cfg_row(CFG_PRESS_LIMIT, 8'd1));
    plan.push_back(tick_row(0, 1, 1));
    plan.push_back(tick_row(0, 0, 1));
    plan.push_back(cfg_row(CFG_PRESS_LIMIT, 8'd2));
    plan.push_back(tick_row(0, 1, 2));
    plan.push_back(tick_row(0, 0, 1));

    foreach (plan[i]) begin
      r = plan[i];
      if (r.kind == ROW_CFG) begin
        settle();
        write_reg(r.index, r.value);
      end else begin
        steady = (r.count > 1000);
        for (int unsigned k = 0; k < r.count; k++)
          send_tick(r.start_level, r.hold_level, r.typed && (k == r.count - 1), r.want);
        steady = 1'b0;
      end
    end
    directed_ticks = ticks_sent;

    limit_pick = '{8'd2, 8'd224, 8'd225, 8'd70, 8'd0, 8'd0};
    hours_pick = '{7'd99, 7'd1, 7'd127, 7'd0, 7'd0, 7'd0};
    limit_pick[4] = $urandom_range(3, 223);
    limit_pick[5] = $urandom_range(3, 223);
    hours_pick[4] = $urandom_range(1, 99);
    hours_pick[5] = $urandom_range(1, 99);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(CFG_PRESS_LIMIT, limit_pick[p]);
      write_reg(CFG_HOURS_MAX, {1'b0, hours_pick[p]});
      steady = (p == 3);
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < PHASE_TICKS) begin
        choice = $urandom_range(0, 9);
        if (choice < 7) begin
          // press and release: start, hold or both
          kind = $urandom_range(0, 2);
          span = (limit_reg > 31) ? 30 : ((limit_reg >= 2) ? limit_reg - 1 : 1);
          if ($urandom_range(0, 19) == 0) len = 230;
          else if (limit_reg >= 2 && $urandom_range(0, 3) != 0) len = $urandom_range(1, span);
          else len = $urandom_range(1, 40);
          repeat (len) send_tick(kind != 1, kind != 0);
          send_tick(1'b0, 1'b0);
          repeat ($urandom_range(0, 4)) send_tick(1'b0, 1'b0);
        end else begin
          repeat ($urandom_range(1, 8)) send_tick($urandom_range(0, 1), $urandom_range(0, 1));
        end
      end
      steady = 1'b0;
    end

    settle();
    repeat (10) @(negedge clk);
    $display("sent %0d ticks (%0d in the directed table: second carry, limits, clear, hold)",
             ticks_sent, directed_ticks);
    $display("compared %0d readouts across %0d register writes and %0d random phases",
             readouts_seen, cfg_writes, PHASES);
    if (error_count == 0 && readouts_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/sw_pkg.sv
rtl/sw_stream_if.sv
rtl/stopwatch_with_button_qualifiers.sv
verif/stopwatch_with_button_qualifiers_test.sv
